>>> rtl/modinv_pkg.sv
// ----------------------------------------------------------------------------
// modinv_pkg
// Types, microcode layout and the control store of the modular inverse block.
// ----------------------------------------------------------------------------
package modinv_pkg;

    // Width of the microprogram counter.
    localparam int UPC_W = 4;

    // Datapath operations, one per control word.
    typedef enum logic [2:0] {
        OP_NOP,
        OP_INIT,
        OP_DSTEP,
        OP_SET_R,
        OP_LOAD_DIV,
        OP_ROTATE,
        OP_REDUCE,
        OP_EMIT
    } op_t;

    // Jump conditions, tested on the state before the step's update.
    typedef enum logic [2:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_P_ZERO,
        COND_P_ONE,
        COND_DIV_MORE,
        COND_R_ZERO,
        COND_ROLD_NE1
    } cond_t;

    // What an emit step places on the result ports.
    typedef enum logic [1:0] {
        RES_OK,
        RES_FAIL,
        RES_ONE
    } res_t;

    // One control word.
    typedef struct packed {
        op_t               op;
        cond_t             cond;
        res_t              res;
        logic [UPC_W-1:0]  target;
    } ucode_t;

    // Program addresses.
    localparam logic [UPC_W-1:0] A_CHK_ZERO = 4'd0;
    localparam logic [UPC_W-1:0] A_CHK_ONE  = 4'd1;
    localparam logic [UPC_W-1:0] A_INIT     = 4'd2;
    localparam logic [UPC_W-1:0] A_DIV0     = 4'd3;
    localparam logic [UPC_W-1:0] A_SET_R    = 4'd4;
    localparam logic [UPC_W-1:0] A_LOOP     = 4'd5;
    localparam logic [UPC_W-1:0] A_LOAD     = 4'd6;
    localparam logic [UPC_W-1:0] A_DIV      = 4'd7;
    localparam logic [UPC_W-1:0] A_ROTATE   = 4'd8;
    localparam logic [UPC_W-1:0] A_GCD_CHK  = 4'd9;
    localparam logic [UPC_W-1:0] A_REDUCE   = 4'd10;
    localparam logic [UPC_W-1:0] A_EMIT_OK  = 4'd11;
    localparam logic [UPC_W-1:0] A_FAIL     = 4'd12;
    localparam logic [UPC_W-1:0] A_ONE      = 4'd13;

    // Control store: the extended Euclid program.
    function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] addr);
        ucode_t w;
        w = '{op: OP_NOP, cond: COND_NONE, res: RES_OK, target: A_CHK_ZERO};
        unique case (addr)
            A_CHK_ZERO: w = '{OP_NOP,      COND_P_ZERO,   RES_OK,   A_FAIL};
            A_CHK_ONE:  w = '{OP_NOP,      COND_P_ONE,    RES_OK,   A_ONE};
            A_INIT:     w = '{OP_INIT,     COND_NONE,     RES_OK,   A_CHK_ZERO};
            A_DIV0:     w = '{OP_DSTEP,    COND_DIV_MORE, RES_OK,   A_DIV0};
            A_SET_R:    w = '{OP_SET_R,    COND_NONE,     RES_OK,   A_CHK_ZERO};
            A_LOOP:     w = '{OP_NOP,      COND_R_ZERO,   RES_OK,   A_GCD_CHK};
            A_LOAD:     w = '{OP_LOAD_DIV, COND_NONE,     RES_OK,   A_CHK_ZERO};
            A_DIV:      w = '{OP_DSTEP,    COND_DIV_MORE, RES_OK,   A_DIV};
            A_ROTATE:   w = '{OP_ROTATE,   COND_ALWAYS,   RES_OK,   A_LOOP};
            A_GCD_CHK:  w = '{OP_NOP,      COND_ROLD_NE1, RES_OK,   A_FAIL};
            A_REDUCE:   w = '{OP_REDUCE,   COND_NONE,     RES_OK,   A_CHK_ZERO};
            A_EMIT_OK:  w = '{OP_EMIT,     COND_NONE,     RES_OK,   A_CHK_ZERO};
            A_FAIL:     w = '{OP_EMIT,     COND_NONE,     RES_FAIL, A_CHK_ZERO};
            A_ONE:      w = '{OP_EMIT,     COND_NONE,     RES_ONE,  A_CHK_ZERO};
            default:    w = '{OP_EMIT,     COND_NONE,     RES_FAIL, A_CHK_ZERO};
        endcase
        return w;
    endfunction

endpackage

>>> rtl/modular_inverse.sv
// ----------------------------------------------------------------------------
// modular_inverse
// Inverse of a value modulo a programmable modulus, by the extended Euclidean
// algorithm run from a small microprogram over a radix-2 divider.
// ----------------------------------------------------------------------------
//
// Channel    Ports                              Handshake
// request    start, value                       taken when start & !busy
// result     done, inverse, not_invertible      one-cycle strobe on done
// config     modulus_we, modulus                written when modulus_we
//
// Flow: a modulus of 0 fails at once and a modulus of 1 returns 1. Otherwise
// the value is first reduced modulo the modulus, each Euclid round loads and
// runs one division and rotates the remainders and coefficients, and a final
// check and fold emit the result (or the failure when not invertible); the
// bit-serial divider produces one quotient bit per cycle.
// Reset leaves the block idle with a modulus of 1. Results cannot be stalled;
// busy stays high from the request and falls in the cycle of its result strobe.
// ----------------------------------------------------------------------------
module modular_inverse
    import modinv_pkg::*;
#(
    parameter int WIDTH = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-2:0] value,
    output logic             busy,
    input  logic             modulus_we,
    input  logic [WIDTH-2:0] modulus,
    output logic             done,
    output logic [WIDTH-2:0] inverse,
    output logic             not_invertible
);

    localparam int FW = WIDTH - 1;          // field width
    localparam int TW = WIDTH;              // coefficient width, holds up to p
    localparam int CW = $clog2(FW + 1);     // divider bit counter

    // Control registers.
    logic             busy_reg, busy_next;
    logic [UPC_W-1:0] pc_reg, pc_next;
    logic             done_reg, done_next;
    logic [FW-1:0]    modulus_reg;

    // Datapath registers.
    logic [FW-1:0] value_reg, value_next;
    logic [FW-1:0] r_old_reg, r_old_next;
    logic [FW-1:0] r_reg, r_next;
    logic [TW-1:0] t_old_reg, t_old_next;
    logic [TW-1:0] t_cur_reg, t_cur_next;
    logic          old_neg_reg, old_neg_next;
    logic          cur_neg_reg, cur_neg_next;
    logic [FW-1:0] dvd_reg, dvd_next;
    logic [FW-1:0] dvs_reg, dvs_next;
    logic [FW-1:0] rem_reg, rem_next;
    logic [TW-1:0] acc_reg, acc_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [FW-1:0] inverse_reg, inverse_next;
    logic          flag_reg, flag_next;

    // Decoded control word and divider step signals.
    ucode_t        uw;
    logic          take;
    logic [FW:0]   rem_sh;
    logic [FW:0]   rem_diff;
    logic          q_bit;

    assign uw = ucode_rom(pc_reg);

    // One restoring division step: shift in the next dividend bit, compare.
    assign rem_sh   = {rem_reg, dvd_reg[FW-1]};
    assign q_bit    = (rem_sh >= {1'b0, dvs_reg});
    assign rem_diff = rem_sh - {1'b0, dvs_reg};

    // Jump condition, tested on the current state.
    always_comb
    begin
        take = 1'b0;
        unique case (uw.cond)
            COND_NONE:     take = 1'b0;
            COND_ALWAYS:   take = 1'b1;
            COND_P_ZERO:   take = (modulus_reg == '0);
            COND_P_ONE:    take = (modulus_reg == FW'(1));
            COND_DIV_MORE: take = (cnt_reg != CW'(1));
            COND_R_ZERO:   take = (r_reg == '0);
            COND_ROLD_NE1: take = (r_old_reg != FW'(1));
            default:       take = 1'b0;
        endcase
    end

    // Sequencer: request acceptance, program counter and result strobe.
    always_comb
    begin
        busy_next  = busy_reg;
        pc_next    = pc_reg;
        done_next  = 1'b0;
        value_next = value_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next  = 1'b1;
                pc_next    = A_CHK_ZERO;
                value_next = value;
            end
        end
        else if (uw.op == OP_EMIT)
        begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
        else if (take)
        begin
            pc_next = uw.target;
        end
        else
        begin
            pc_next = pc_reg + UPC_W'(1);
        end
    end

    // Datapath: each control word selects one register transfer.
    always_comb
    begin
        r_old_next   = r_old_reg;
        r_next       = r_reg;
        t_old_next   = t_old_reg;
        t_cur_next   = t_cur_reg;
        old_neg_next = old_neg_reg;
        cur_neg_next = cur_neg_reg;
        dvd_next     = dvd_reg;
        dvs_next     = dvs_reg;
        rem_next     = rem_reg;
        acc_next     = acc_reg;
        cnt_next     = cnt_reg;
        inverse_next = inverse_reg;
        flag_next    = flag_reg;
        if (busy_reg)
        begin
            case (uw.op)
                OP_INIT:
                begin
                    r_old_next   = modulus_reg;
                    t_old_next   = '0;
                    t_cur_next   = TW'(1);
                    old_neg_next = 1'b1;
                    cur_neg_next = 1'b0;
                    dvd_next     = value_reg;
                    dvs_next     = modulus_reg;
                    rem_next     = '0;
                    acc_next     = '0;
                    cnt_next     = CW'(FW);
                end
                OP_LOAD_DIV:
                begin
                    dvd_next = r_old_reg;
                    dvs_next = r_reg;
                    rem_next = '0;
                    acc_next = '0;
                    cnt_next = CW'(FW);
                end
                OP_DSTEP:
                begin
                    rem_next = q_bit ? rem_diff[FW-1:0] : rem_sh[FW-1:0];
                    dvd_next = {dvd_reg[FW-2:0], 1'b0};
                    // Quotient times coefficient, built MSB first.
                    acc_next = {acc_reg[TW-2:0], 1'b0} + (q_bit ? t_cur_reg : '0);
                    cnt_next = cnt_reg - CW'(1);
                end
                OP_SET_R:
                begin
                    r_next = rem_reg;
                end
                OP_ROTATE:
                begin
                    r_old_next   = r_reg;
                    r_next       = rem_reg;
                    t_old_next   = t_cur_reg;
                    t_cur_next   = t_old_reg + acc_reg;
                    old_neg_next = cur_neg_reg;
                    cur_neg_next = !cur_neg_reg;
                end
                OP_REDUCE:
                begin
                    if (t_old_reg >= {1'b0, modulus_reg})
                    begin
                        t_old_next = t_old_reg - {1'b0, modulus_reg};
                    end
                end
                OP_EMIT:
                begin
                    case (uw.res)
                        RES_OK:
                        begin
                            flag_next = 1'b0;
                            // A negative coefficient folds back as p - |t|.
                            if (old_neg_reg && (t_old_reg != '0))
                            begin
                                inverse_next = modulus_reg - t_old_reg[FW-1:0];
                            end
                            else
                            begin
                                inverse_next = t_old_reg[FW-1:0];
                            end
                        end
                        RES_ONE:
                        begin
                            inverse_next = FW'(1);
                            flag_next    = 1'b0;
                        end
                        default:
                        begin
                            inverse_next = '0;
                            flag_next    = 1'b1;
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
    end

    // Control state, set by reset (modulus to 1, the rest cleared).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            pc_reg      <= A_CHK_ZERO;
            done_reg    <= 1'b0;
            modulus_reg <= FW'(1);
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
            done_reg <= done_next;
            if (modulus_we)
            begin
                modulus_reg <= modulus;
            end
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge clk)
    begin
        value_reg   <= value_next;
        r_old_reg   <= r_old_next;
        r_reg       <= r_next;
        t_old_reg   <= t_old_next;
        t_cur_reg   <= t_cur_next;
        old_neg_reg <= old_neg_next;
        cur_neg_reg <= cur_neg_next;
        dvd_reg     <= dvd_next;
        dvs_reg     <= dvs_next;
        rem_reg     <= rem_next;
        acc_reg     <= acc_next;
        cnt_reg     <= cnt_next;
        inverse_reg <= inverse_next;
        flag_reg    <= flag_next;
    end

    assign busy           = busy_reg;
    assign done           = done_reg;
    assign inverse        = inverse_reg;
    assign not_invertible = flag_reg;

endmodule
